// ===== rtl/two_level_write_back_cache_unit_defines.svh =====
// assertion macros for the two-level cache unit
// no dependencies
`ifndef TWO_LEVEL_WRITE_BACK_CACHE_UNIT_DEFINES_SVH
`define TWO_LEVEL_WRITE_BACK_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define TLC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define TLC_ASSERT(lbl, clk, rst_n, prop)
`define TLC_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== rtl/tlc_pkg.sv =====
// shared types and constants for the two-level cache unit
// no dependencies
`default_nettype none
package tlc_pkg;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned LineWords = 4;
  localparam int unsigned L1Lines   = 256;
  localparam int unsigned L2Lines   = 512;
  localparam int unsigned MemLines  = 1024;
  localparam int unsigned AddrBits  = 12;
  localparam int unsigned CostBits  = 11;
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [CfgIdxBits-1:0] CfgMemRd = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgMemWr = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgL1Rd  = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgL1Wr  = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgL2Rd  = 3'd4;

  // controller states, one-hot
  typedef enum logic [11:0] {
    StClear  = 12'b000000000001,
    StIdle   = 12'b000000000010,
    StL1Rd   = 12'b000000000100,
    StL1Chk  = 12'b000000001000,
    StL2Rd   = 12'b000000010000,
    StL2Chk  = 12'b000000100000,
    StMemWr  = 12'b000001000000,
    StMemRd  = 12'b000010000000,
    StMemFin = 12'b000100000000,
    StL2Fin  = 12'b001000000000,
    StL1Fin  = 12'b010000000000,
    StOut    = 12'b100000000000
  } tlc_state_e;

  // datapath commands
  typedef struct packed {
    logic clr_step;   // write zero to memory at clear pointer
    logic start;      // capture input item
    logic l1_rd;      // read l1 entry
    logic l2_rd_vict; // start l2 access for l1 victim
    logic l2_rd_fill; // start l2 access for fill line
    logic l2_rd;      // read l2 entry at current line
    logic mem_wr;     // write l2 victim to memory
    logic mem_rd;     // read memory at current line
    logic mem_fin;    // load memory line into l2
    logic l2_fin;     // finish l2 hit access
    logic l1_fin;     // finish word access into l1
    logic out_take;   // result taken
  } tlc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic l1_hit;
    logic l1_vict;    // l1 victim dirty
    logic l2_hit;
    logic l2_vict;    // l2 victim dirty
    logic in_vict;    // current l2 access is the victim write
  } tlc_sts_t;
endpackage
`default_nettype wire

// ===== rtl/two_level_write_back_cache_unit.sv =====
// top level of the two-level direct-mapped write-back cache unit
// depends on tlc_pkg, tlc_ctrl, tlc_datapath and the defines header
//
// usage: an item (command, word_address, write_data) enters on in_valid_i /
// in_ready_o; one result item leaves on out_valid_o / out_ready_i with the
// read word, hit flags, access cost and the wrapping time total.
// configuration: cfg_we_i with cfg_idx_i and cfg_data_i writes one cost
// register; unknown indexes are ignored.
// sequence: an l1 hit passes the l1 read, check and finish states before the
// result; an l1 miss adds an l2 lookup (two when a dirty l1 victim goes to
// l2), a memory read per l2 miss and a memory write when a dirty l2 victim
// goes to memory. one item is in work at a time, set by the controller state
// machine; the next is accepted the cycle after the result is taken.
// reset: all valid and dirty bits clear at once; main memory is then zeroed
// one line a cycle, all MEM_LINES lines (1024 by default), before in_ready_o
// rises. configuration writes are taken during that pass.
// stall: the result holds until out_ready_i; no new item is taken meanwhile.
`default_nettype none
`include "two_level_write_back_cache_unit_defines.svh"
module two_level_write_back_cache_unit import tlc_pkg::*; #(
  parameter int unsigned WORD_BITS  = WordBits,
  parameter int unsigned LINE_WORDS = LineWords,
  parameter int unsigned L1_LINES   = L1Lines,
  parameter int unsigned L2_LINES   = L2Lines,
  parameter int unsigned MEM_LINES  = MemLines
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [7:0]            cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  command_i,
  input  wire logic [AddrBits-1:0]   word_address_i,
  input  wire logic [WORD_BITS-1:0]  write_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [WORD_BITS-1:0]       read_data_o,
  output logic                       l1_hit_o,
  output logic                       l2_hit_o,
  output logic [CostBits-1:0]        access_cost_o,
  output logic [31:0]                total_time_o
);
  tlc_cmd_t cmd;
  tlc_sts_t sts;

  tlc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  tlc_datapath #(
    .WORD_BITS(WORD_BITS), .LINE_WORDS(LINE_WORDS), .L1_LINES(L1_LINES),
    .L2_LINES(L2_LINES), .MEM_LINES(MEM_LINES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .command_i, .word_address_i, .write_data_i, .read_data_o, .l1_hit_o,
    .l2_hit_o, .access_cost_o, .total_time_o
  );

  `TLC_ASSERT(a_no_in_out, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `TLC_ASSERT(a_hit_excl, clk_i, rst_ni, out_valid_o |-> !(l1_hit_o && l2_hit_o))
  `TLC_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `TLC_ASSERT(a_take_ready, clk_i, rst_ni, (out_valid_o && out_ready_i) |=> in_ready_o)
endmodule
`default_nettype wire

// ===== rtl/tlc_datapath.sv =====
// datapath: l1, l2 and main memory arrays, tags, cost and time registers
// depends on tlc_pkg
`default_nettype none
module tlc_datapath import tlc_pkg::*; #(
  parameter int unsigned WORD_BITS  = WordBits,
  parameter int unsigned LINE_WORDS = LineWords,
  parameter int unsigned L1_LINES   = L1Lines,
  parameter int unsigned L2_LINES   = L2Lines,
  parameter int unsigned MEM_LINES  = MemLines
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tlc_cmd_t              cmd_i,
  output tlc_sts_t                   sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [7:0]            cfg_data_i,
  input  wire logic                  command_i,
  input  wire logic [AddrBits-1:0]   word_address_i,
  input  wire logic [WORD_BITS-1:0]  write_data_i,
  output logic [WORD_BITS-1:0]       read_data_o,
  output logic                       l1_hit_o,
  output logic                       l2_hit_o,
  output logic [CostBits-1:0]        access_cost_o,
  output logic [31:0]                total_time_o
);
  localparam int unsigned LineBits = WORD_BITS * LINE_WORDS;
  localparam int unsigned OffBits  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int unsigned MlBits   = $clog2(MEM_LINES);
  localparam int unsigned I1Bits   = $clog2(L1_LINES);
  localparam int unsigned I2Bits   = $clog2(L2_LINES);
  localparam int unsigned T1Bits   = (MlBits > I1Bits) ? MlBits - I1Bits : 1;
  localparam int unsigned T2Bits   = (MlBits > I2Bits) ? MlBits - I2Bits : 1;
  localparam int unsigned L1Mod    = (L1_LINES < MEM_LINES) ? L1_LINES : MEM_LINES;
  localparam int unsigned L2Mod    = (L2_LINES < MEM_LINES) ? L2_LINES : MEM_LINES;

  logic [7:0] mem_rd_c_q, mem_wr_c_q, l1_rd_c_q, l1_wr_c_q, l2_rd_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_rd_c_q <= 8'd100; mem_wr_c_q <= 8'd50;
      l1_rd_c_q <= 8'd1; l1_wr_c_q <= 8'd1; l2_rd_c_q <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMemRd: mem_rd_c_q <= cfg_data_i;
        CfgMemWr: mem_wr_c_q <= cfg_data_i;
        CfgL1Rd:  l1_rd_c_q  <= cfg_data_i;
        CfgL1Wr:  l1_wr_c_q  <= cfg_data_i;
        CfgL2Rd:  l2_rd_c_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item registers
  logic                 wr_q;
  logic [MlBits-1:0]    ln_q;
  logic [OffBits-1:0]   off_q;
  logic [WORD_BITS-1:0] wdata_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wr_q    <= command_i;
      ln_q    <= MlBits'((word_address_i >> OffBits*(LINE_WORDS > 1)) % MEM_LINES);
      off_q   <= (LINE_WORDS > 1) ? OffBits'(word_address_i) : '0;
      wdata_q <= write_data_i;
    end
  end
  logic [I1Bits-1:0] i1;
  logic [T1Bits-1:0] t1;
  assign i1 = I1Bits'(ln_q % L1Mod);
  assign t1 = T1Bits'(ln_q / L1_LINES);

  // l1 arrays
  logic [L1_LINES-1:0] l1_v_q, l1_d_q;
  logic [T1Bits-1:0] l1_tag_mem [L1_LINES];
  logic [LineBits-1:0] l1_dat_mem [L1_LINES];
  logic [T1Bits-1:0] l1_tag_q;
  logic [LineBits-1:0] l1_line_q;   // working line buffer
  logic l1_vq, l1_dq;
  logic [LineBits-1:0] l2_buf_q;    // line moving into/out of l2
  logic l1_fill_q;                  // l1 missed: line comes from l2 buffer
  logic [LineBits-1:0] base_line, wline;

  always_ff @(posedge clk_i) begin
    if (cmd_i.l1_rd) begin
      l1_tag_q  <= l1_tag_mem[i1];
      l1_line_q <= l1_dat_mem[i1];
    end
    if (cmd_i.l1_fin) begin
      l1_tag_mem[i1] <= t1;
      l1_dat_mem[i1] <= wline;
    end
  end
  assign base_line = l1_fill_q ? l2_buf_q : l1_line_q;
  always_comb begin
    wline = base_line;
    if (wr_q) wline[off_q*WORD_BITS +: WORD_BITS] = wdata_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_v_q <= '0; l1_d_q <= '0; l1_vq <= 1'b0; l1_dq <= 1'b0;
    end else begin
      if (cmd_i.l1_rd) begin
        l1_vq <= l1_v_q[i1]; l1_dq <= l1_d_q[i1];
      end
      if (cmd_i.l1_fin) begin
        l1_v_q[i1] <= 1'b1;
        l1_d_q[i1] <= wr_q | (~l1_fill_q & l1_dq);
      end
    end
  end
  logic hit1;
  assign hit1 = l1_vq && (l1_tag_q == t1);
  logic [MlBits-1:0] v1_ln;
  assign v1_ln = MlBits'(({l1_tag_q, i1}) % MEM_LINES);

  // l2 access line and arrays
  logic [MlBits-1:0] l2ln_q;
  logic vict_q, l2wr_q;
  logic [I2Bits-1:0] i2;
  logic [T2Bits-1:0] t2;
  assign i2 = I2Bits'(l2ln_q % L2Mod);
  assign t2 = T2Bits'(l2ln_q / L2_LINES);
  logic [L2_LINES-1:0] l2_v_q, l2_d_q;
  logic [T2Bits-1:0] l2_tag_mem [L2_LINES];
  logic [LineBits-1:0] l2_dat_mem [L2_LINES];
  logic [T2Bits-1:0] l2_tag_q;
  logic [LineBits-1:0] l2_rdat_q;
  logic l2_vq, l2_dq;
  logic hit2;
  assign hit2 = l2_vq && (l2_tag_q == t2);
  logic [MlBits-1:0] v2_ln;
  assign v2_ln = MlBits'(({l2_tag_q, i2}) % MEM_LINES);

  logic [LineBits-1:0] mem_rdat_q;
  logic l2_wr_en;
  logic [LineBits-1:0] l2_wdat;
  assign l2_wr_en = cmd_i.mem_fin | (cmd_i.l2_fin & l2wr_q);
  assign l2_wdat  = l2wr_q ? l2_buf_q : mem_rdat_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.l2_rd) begin
      l2_tag_q  <= l2_tag_mem[i2];
      l2_rdat_q <= l2_dat_mem[i2];
    end
    if (l2_wr_en) begin
      l2_tag_mem[i2] <= t2;
      l2_dat_mem[i2] <= l2_wdat;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l2_v_q <= '0; l2_d_q <= '0; l2_vq <= 1'b0; l2_dq <= 1'b0;
    end else begin
      if (cmd_i.l2_rd) begin
        l2_vq <= l2_v_q[i2]; l2_dq <= l2_d_q[i2];
      end
      if (l2_wr_en) begin
        l2_v_q[i2] <= 1'b1;
        l2_d_q[i2] <= l2wr_q;
      end
    end
  end

  // main memory with clearing pass
  logic [LineBits-1:0] main_mem [MEM_LINES];
  logic [MlBits:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) main_mem[clr_q[MlBits-1:0]] <= '0;
    else if (cmd_i.mem_wr) main_mem[v2_ln] <= l2_rdat_q;
    if (cmd_i.mem_rd) mem_rdat_q <= main_mem[l2ln_q];
  end

  // l2 access setup, buffer and cost
  logic [CostBits-1:0] cost_q;
  logic hit2_out_q;
  logic [31:0] time_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic hit1_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0; cost_q <= '0; vict_q <= 1'b0; l2wr_q <= 1'b0; l2ln_q <= '0;
      l1_fill_q <= 1'b0; hit2_out_q <= 1'b0; hit1_out_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cost_q <= '0; l1_fill_q <= 1'b0; hit2_out_q <= 1'b0;
      end
      if (cmd_i.l2_rd_vict) begin
        vict_q <= 1'b1; l2wr_q <= 1'b1; l2ln_q <= v1_ln;
      end
      if (cmd_i.l2_rd_fill) begin
        vict_q <= 1'b0; l2wr_q <= 1'b0; l2ln_q <= ln_q; l1_fill_q <= 1'b1;
      end
      if (cmd_i.mem_wr) cost_q <= cost_q + CostBits'(mem_wr_c_q);
      if (cmd_i.mem_fin)
        cost_q <= cost_q + CostBits'(mem_rd_c_q) + (l2wr_q ? '0 : CostBits'(l2_rd_c_q));
      if (cmd_i.l2_fin)
        cost_q <= cost_q + CostBits'(l2wr_q ? l1_wr_c_q : l1_rd_c_q);
      if (cmd_i.l2_fin & ~vict_q) hit2_out_q <= 1'b1;
      if (cmd_i.l1_fin) begin
        cost_q <= cost_q + CostBits'(wr_q ? l1_wr_c_q : l1_rd_c_q);
        time_q <= time_q + 32'(cost_q) + 32'(wr_q ? l1_wr_c_q : l1_rd_c_q);
        hit1_out_q <= ~l1_fill_q;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.l1_rd) l2_buf_q <= l1_dat_mem[i1];
    else if (cmd_i.mem_fin & ~l2wr_q) l2_buf_q <= mem_rdat_q;
    else if (cmd_i.l2_fin & ~l2wr_q) l2_buf_q <= l2_rdat_q;
    if (cmd_i.l1_fin) rdata_q <= wr_q ? '0 : base_line[off_q*WORD_BITS +: WORD_BITS];
  end

  assign sts_o.clr_done = clr_q[MlBits];
  assign sts_o.l1_hit   = hit1;
  assign sts_o.l1_vict  = l1_vq & l1_dq;
  assign sts_o.l2_hit   = hit2;
  assign sts_o.l2_vict  = l2_vq & l2_dq;
  assign sts_o.in_vict  = vict_q;

  assign read_data_o   = rdata_q;
  assign l1_hit_o      = hit1_out_q;
  assign l2_hit_o      = hit2_out_q;
  assign access_cost_o = cost_q;
  assign total_time_o  = time_q;
endmodule
`default_nettype wire

// ===== rtl/tlc_ctrl.sv =====
// controller state machine sequencing l1, l2 and memory steps
// depends on tlc_pkg
`default_nettype none
module tlc_ctrl import tlc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire tlc_sts_t sts_i,
  output tlc_cmd_t      cmd_o
);
  tlc_state_e state_q, state_d;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StClear: begin
        if (sts_i.clr_done) state_d = StIdle;
        else cmd_o.clr_step = 1'b1;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1; state_d = StL1Rd;
        end
      end
      StL1Rd: begin
        cmd_o.l1_rd = 1'b1; state_d = StL1Chk;
      end
      StL1Chk: begin
        if (sts_i.l1_hit) state_d = StL1Fin;
        else begin
          if (sts_i.l1_vict) cmd_o.l2_rd_vict = 1'b1;
          else cmd_o.l2_rd_fill = 1'b1;
          state_d = StL2Rd;
        end
      end
      StL2Rd: begin
        cmd_o.l2_rd = 1'b1; state_d = StL2Chk;
      end
      StL2Chk: begin
        if (sts_i.l2_hit) state_d = StL2Fin;
        else if (sts_i.l2_vict) state_d = StMemWr;
        else state_d = StMemRd;
      end
      StMemWr: begin
        cmd_o.mem_wr = 1'b1; state_d = StMemRd;
      end
      StMemRd: begin
        cmd_o.mem_rd = 1'b1; state_d = StMemFin;
      end
      StMemFin: begin
        cmd_o.mem_fin = 1'b1;
        state_d = sts_i.in_vict ? StL2Rd : StL1Fin;
        if (sts_i.in_vict) cmd_o.l2_rd_fill = 1'b1;
      end
      StL2Fin: begin
        cmd_o.l2_fin = 1'b1;
        state_d = sts_i.in_vict ? StL2Rd : StL1Fin;
        if (sts_i.in_vict) cmd_o.l2_rd_fill = 1'b1;
      end
      StL1Fin: begin
        cmd_o.l1_fin = 1'b1; state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_take = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

// ===== dv/two_level_write_back_cache_unit_tb.sv =====
// self-checking testbench for the two-level write-back cache unit
// drives word reads and writes, predicts each result item and compares it
// depends on tlc_pkg and the two_level_write_back_cache_unit rtl
`default_nettype none
module two_level_write_back_cache_unit_tb;
  import tlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [LineWords*WordBits-1:0] line_t;

  typedef struct packed {
    logic [WordBits-1:0] rdata;
    logic                hit1;
    logic                hit2;
    logic [CostBits-1:0] cost;
    logic [31:0]         total;
  } access_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [AddrBits-1:0] word_address = '0;
  logic [WordBits-1:0] write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WordBits-1:0] read_data;
  logic l1_hit, l2_hit;
  logic [CostBits-1:0] access_cost;
  logic [31:0] total_time;

  two_level_write_back_cache_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .word_address_i(word_address), .write_data_i(write_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .read_data_o(read_data), .l1_hit_o(l1_hit), .l2_hit_o(l2_hit),
    .access_cost_o(access_cost), .total_time_o(total_time)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10ms;
    $display("two_level_write_back_cache_unit regression: fail");
    $finish;
  end

  // shadow copy of the cache hierarchy
  logic [7:0] c_mem_rd, c_mem_wr, c_l1_rd, c_l1_wr, c_l2_rd;
  logic       s1_valid [L1Lines];
  logic       s1_dirty [L1Lines];
  logic [1:0] s1_tag   [L1Lines];
  line_t      s1_data  [L1Lines];
  logic       s2_valid [L2Lines];
  logic       s2_dirty [L2Lines];
  logic       s2_tag   [L2Lines];
  line_t      s2_data  [L2Lines];
  line_t      s_mem    [MemLines];
  logic [31:0] s_total;

  access_result_t pending_results[$];
  int errors = 0;
  bit valid_high = 0;
  bit no_idle = 0;
  int hold_cycles = 0;

  task automatic l2_line_xfer(input int ln, inout line_t buf_line, input bit wr,
                              inout int cost, output bit hit);
    int idx, tg, vl;
    idx = ln % L2Lines;
    tg = ln / L2Lines;
    hit = s2_valid[idx] && s2_tag[idx] == tg;
    if (!hit) begin
      if (s2_valid[idx] && s2_dirty[idx]) begin
        vl = (s2_tag[idx] * L2Lines + idx) % MemLines;
        s_mem[vl] = s2_data[idx];
        cost += c_mem_wr;
      end
      s2_data[idx] = s_mem[ln];
      cost += c_mem_rd;
      s2_valid[idx] = 1;
      s2_tag[idx] = tg[0];
      s2_dirty[idx] = 0;
      if (wr) begin
        s2_data[idx] = buf_line;
        s2_dirty[idx] = 1;
      end else begin
        buf_line = s2_data[idx];
        cost += c_l2_rd;
      end
    end else if (wr) begin
      s2_data[idx] = buf_line;
      s2_dirty[idx] = 1;
      cost += c_l1_wr;
    end else begin
      buf_line = s2_data[idx];
      cost += c_l1_rd;
    end
  endtask

  task automatic predict_access(input logic wr, input logic [AddrBits-1:0] addr,
                                input logic [WordBits-1:0] wdata);
    int ln, off, idx, tg, cost;
    bit h1, h2, dummy;
    line_t ln_buf;
    access_result_t r;
    ln = (addr / LineWords) % MemLines;
    off = addr % LineWords;
    idx = ln % L1Lines;
    tg = ln / L1Lines;
    cost = 0;
    h2 = 0;
    r.rdata = '0;
    h1 = s1_valid[idx] && s1_tag[idx] == tg;
    if (!h1) begin
      if (s1_valid[idx] && s1_dirty[idx]) begin
        ln_buf = s1_data[idx];
        l2_line_xfer((s1_tag[idx] * L1Lines + idx) % MemLines, ln_buf, 1, cost, dummy);
      end
      l2_line_xfer(ln, ln_buf, 0, cost, h2);
      s1_data[idx] = ln_buf;
      s1_valid[idx] = 1;
      s1_tag[idx] = tg[1:0];
      s1_dirty[idx] = 0;
    end
    if (wr) begin
      s1_data[idx][off*WordBits +: WordBits] = wdata;
      s1_dirty[idx] = 1;
      cost += c_l1_wr;
    end else begin
      r.rdata = s1_data[idx][off*WordBits +: WordBits];
      cost += c_l1_rd;
    end
    s_total += cost;
    r.hit1 = h1;
    r.hit2 = h2;
    r.cost = cost[CostBits-1:0];
    r.total = s_total;
    pending_results.push_back(r);
  endtask

  // result checker
  always @(posedge clk_i) begin
    access_result_t e;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (e.rdata !== read_data || e.hit1 !== l1_hit || e.hit2 !== l2_hit ||
            e.cost !== access_cost || e.total !== total_time) begin
          errors++;
          if (errors <= 10)
            $display("mismatch at %0t: exp data %h l1 %b l2 %b cost %0d total %0d, got %h %b %b %0d %0d",
                     $realtime, e.rdata, e.hit1, e.hit2, e.cost, e.total,
                     read_data, l1_hit, l2_hit, access_cost, total_time);
        end
      end
    end
  end

  // receiver ready with random stalls and an optional long hold-off
  initial begin
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 17);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        @(negedge clk_i) out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid && out_ready)) @(posedge clk_i);
    end
  end

  task automatic send_access(input logic wr, input logic [AddrBits-1:0] addr,
                             input logic [WordBits-1:0] wdata);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk_i) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    command <= wr;
    word_address <= addr;
    write_data <= wdata;
    valid_high = 1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_access(wr, addr, wdata);
  endtask

  task automatic wait_drained();
    if (valid_high) begin
      @(negedge clk_i) in_valid <= 1'b0;
      valid_high = 0;
    end
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_costs(input logic [7:0] mrd, mwr, l1r, l1w, l2r);
    logic [7:0] vals[5];
    logic [CfgIdxBits-1:0] regs[5];
    vals = '{mrd, mwr, l1r, l1w, l2r};
    regs = '{CfgMemRd, CfgMemWr, CfgL1Rd, CfgL1Wr, CfgL2Rd};
    wait_drained();
    repeat (10) @(negedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= regs[i];
      cfg_data <= vals[i];
      @(negedge clk_i);
    end
    c_mem_rd = mrd; c_mem_wr = mwr; c_l1_rd = l1r; c_l1_wr = l1w; c_l2_rd = l2r;
    // an index past the last register must be ignored
    cfg_idx <= CfgIdxBits'(CfgL2Rd + 1 + $urandom_range(0, 2));
    cfg_data <= 8'($urandom);
    @(negedge clk_i) cfg_we <= 1'b0;
  endtask

  function automatic logic [AddrBits-1:0] pick_address();
    // a few l1 sets with all four tags give hits, conflicts and dirty victims
    if ($urandom_range(0, 9) < 7)
      return {2'($urandom_range(0, 3)), 8'($urandom_range(0, 5)), 2'($urandom)};
    return AddrBits'($urandom);
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++)
      send_access(1'($urandom_range(0, 1)), pick_address(), 32'($urandom));
  endtask

  task automatic test_directed();
    send_access(0, 12'h000, 32'h0);
    send_access(1, 12'h000, 32'hffff_ffff);
    send_access(0, 12'h000, 32'h0);
    send_access(1, 12'hfff, 32'h0);
    send_access(0, 12'hfff, 32'hffff_ffff);
    send_access(1, 12'h400, 32'ha5a5_5a5a);  // l1 conflict, dirty victim to l2
    send_access(0, 12'h000, 32'h0);
    send_access(1, 12'h800, 32'h5a5a_a5a5);  // l2 conflict with dirty line
    send_access(0, 12'h400, 32'h0);
    send_access(0, 12'hc00, 32'h0);
    send_access(0, 12'h000, 32'h0);
    send_access(0, 12'h800, 32'h0);
    send_access(1, 12'haaa, 32'haaaa_aaaa);
    send_access(1, 12'h555, 32'h5555_5555);
    send_access(0, 12'haaa, 32'h0);
    send_access(0, 12'h555, 32'h0);
    send_access(0, 12'h2aa, 32'h0);
    send_access(0, 12'h001, 32'h0);
  endtask

  task automatic test_cost_extremes();
    write_costs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_random(80);
    write_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_random(120);
  endtask

  task automatic test_default_traffic();
    write_costs(8'd100, 8'd50, 8'd1, 8'd1, 8'd10);
    run_random(150);
    no_idle = 1;
    run_random(60);
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 400;
    run_random(20);
    wait_drained();
    run_random(20);
  endtask

  task automatic test_mixed_costs();
    write_costs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(90);
    write_costs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(90);
  endtask

  initial begin
    c_mem_rd = 100; c_mem_wr = 50; c_l1_rd = 1; c_l1_wr = 1; c_l2_rd = 10;
    s_total = '0;
    for (int i = 0; i < L1Lines; i++) begin
      s1_valid[i] = 0; s1_dirty[i] = 0; s1_tag[i] = '0; s1_data[i] = '0;
    end
    for (int i = 0; i < L2Lines; i++) begin
      s2_valid[i] = 0; s2_dirty[i] = 0; s2_tag[i] = '0; s2_data[i] = '0;
    end
    for (int i = 0; i < MemLines; i++) s_mem[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_cost_extremes();
    test_default_traffic();
    test_backpressure();
    test_mixed_costs();
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (errors == 0)
      $display("two_level_write_back_cache_unit regression: pass");
    else
      $display("two_level_write_back_cache_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/tlc_pkg.sv
rtl/tlc_datapath.sv
rtl/tlc_ctrl.sv
rtl/two_level_write_back_cache_unit.sv
dv/two_level_write_back_cache_unit_tb.sv
